// ----- src/bcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int unsigned LIMIT_W   = 8;
  localparam int unsigned WINDOW_W  = 16;
  localparam int unsigned TALLY_W   = 2;
  localparam int unsigned MODE_W    = 8;
  localparam int unsigned LAMP_N    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [LIMIT_W-1:0]  DEBOUNCE_LIMIT_RST = 8'd10;
  localparam logic [WINDOW_W-1:0] CLICK_WINDOW_RST   = 16'd300;
  localparam logic [TALLY_W-1:0]  TALLY_MAX          = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW   = 1'd1;

  localparam logic [1:0] MODE_GREEN  = 2'd0;
  localparam logic [1:0] MODE_ORANGE = 2'd1;
  localparam logic [1:0] MODE_RED    = 2'd2;
  localparam logic [1:0] MODE_BLUE   = 2'd3;

  localparam logic [LAMP_N-1:0] LAMP_GREEN  = 4'b0001;
  localparam logic [LAMP_N-1:0] LAMP_ORANGE = 4'b0010;
  localparam logic [LAMP_N-1:0] LAMP_RED    = 4'b0100;
  localparam logic [LAMP_N-1:0] LAMP_BLUE   = 4'b1000;

  typedef struct packed {
    logic [LIMIT_W-1:0]  debounce_limit;
    logic [WINDOW_W-1:0] click_window;
  } bcc_cfg_t;

  // Packed so that pressed_level lands in bit 0 and mode_now in the top bits.
  typedef struct packed {
    logic [MODE_W-1:0] mode_now;
    logic [LAMP_N-1:0] lamps;   // bit 0 green, 1 orange, 2 red, 3 blue
    logic              double_click;
    logic              single_click;
    logic              pressed_level;
  } bcc_result_t;

  function automatic logic [LAMP_N-1:0] lamp_for_mode(input logic [1:0] mode);
    logic [LAMP_N-1:0] lamp;
    case (mode)
      MODE_GREEN:  lamp = LAMP_GREEN;
      MODE_ORANGE: lamp = LAMP_ORANGE;
      MODE_RED:    lamp = LAMP_RED;
      MODE_BLUE:   lamp = LAMP_BLUE;
      default:     lamp = '0;
    endcase
    return lamp;
  endfunction

endpackage

`default_nettype wire

// ----- src/bcc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcc_core
  import bcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        level,
  input  wire bcc_cfg_t    cfg,
  output bcc_result_t      res
);

  logic [LIMIT_W-1:0]  integ_r,  integ_nxt;
  logic                deb_r,    deb_nxt;
  logic [WINDOW_W-1:0] window_r, window_nxt;
  logic [TALLY_W-1:0]  tally_r,  tally_nxt;
  logic [MODE_W-1:0]   mode_r,   mode_nxt;
  logic [LAMP_N-1:0]   lamps_r,  lamps_nxt;
  logic                single_c, double_c;

  always_comb begin
    integ_nxt  = integ_r;
    deb_nxt    = deb_r;
    tally_nxt  = tally_r;
    mode_nxt   = mode_r;
    lamps_nxt  = lamps_r;
    single_c   = 1'b0;
    double_c   = 1'b0;

    // The window counts down before anything else in the tick.
    window_nxt = (window_r != '0) ? window_r - 1'b1 : window_r;

    if (level) begin
      if (integ_r < cfg.debounce_limit) begin
        integ_nxt = integ_r + 1'b1;
      end else if (!deb_r) begin
        if (window_nxt == '0) begin
          window_nxt = cfg.click_window;
        end
        if (tally_r != TALLY_MAX) begin
          tally_nxt = tally_r + 1'b1;
        end
        deb_nxt = 1'b1;
      end
    end else begin
      if (integ_r != '0) begin
        integ_nxt = integ_r - 1'b1;
      end else begin
        deb_nxt = 1'b0;
      end
    end

    if (window_nxt == '0 && tally_nxt != '0) begin
      if (tally_nxt > TALLY_W'(1)) begin
        double_c  = 1'b1;
        mode_nxt  = '0;
        lamps_nxt = '0;
      end else begin
        single_c = 1'b1;
        // Modes beyond blue light nothing but still advance.
        if (mode_r[MODE_W-1:2] == '0) begin
          lamps_nxt = lamps_r | lamp_for_mode(mode_r[1:0]);
        end
        mode_nxt = mode_r + 1'b1;
      end
      tally_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= '0;
      deb_r    <= 1'b0;
      window_r <= '0;
      tally_r  <= '0;
      mode_r   <= '0;
      lamps_r  <= '0;
    end else if (step) begin
      integ_r  <= integ_nxt;
      deb_r    <= deb_nxt;
      window_r <= window_nxt;
      tally_r  <= tally_nxt;
      mode_r   <= mode_nxt;
      lamps_r  <= lamps_nxt;
    end
  end

  always_comb begin
    res.pressed_level = deb_nxt;
    res.single_click  = single_c;
    res.double_click  = double_c;
    res.lamps         = lamps_nxt;
    res.mode_now      = mode_nxt;
  end

`ifndef NO_ASSERTIONS
  // Counted presses are only ever left pending while a window is open.
  a_tally_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    (tally_r != '0) |-> (window_r != '0))
    else $error("press tally pending with no open window");

  a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.single_click && res.double_click))
    else $error("single and double click in the same word");

  a_single_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.single_click) |=> (mode_r == MODE_W'($past(mode_r) + 1'b1)))
    else $error("single click did not advance the mode");

  a_double_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.double_click) |=> (mode_r == '0 && lamps_r == '0))
    else $error("double click did not clear mode and lamps");
`endif

endmodule

`default_nettype wire

// ----- src/bcc_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcc_out_reg
  import bcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire bcc_result_t load_data,
  output logic             load_ready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output bcc_result_t      out_data
);

  logic        valid_r;
  bcc_result_t data_r;

  // A new word may be loaded whenever the held one is gone or leaves now.
  assign load_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_data   = data_r;

endmodule

`default_nettype wire

// ----- src/button_click_classifier_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                          | Word contents (lowest bit first)
// in      | in_tvalid/in_tready/in_tdata   | raw_level, 7 zero bits
// out     | out_tvalid/out_tready/out_tdata| pressed_level, single_click, double_click,
//         |                                | lamp_green..lamp_blue, mode_now[7:0], 0
// cfg     | cfg_we/cfg_addr/cfg_wdata      | 0 debounce_limit, 1 click_window
//
// One word is taken every cycle while the output is not stalled; each result passes
// through the input register, then the classifier logic into the output register.
// Reset is synchronous on rst_n low; config, state and both valid flags return to defaults.
// A stalled output holds its word; the input register still takes one more word,
// after which in_tready follows out_tready.

module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [0] raw_level
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [0] pressed_level, [1] single_click,
                                                 // [2] double_click, [3] lamp_green,
                                                 // [4] lamp_orange, [5] lamp_red,
                                                 // [6] lamp_blue, [14:7] mode_now
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  bcc_cfg_t    cfg_r;
  logic        in_valid_r;
  logic        in_level_r;
  logic        load_ready;
  logic        step;
  bcc_result_t res;
  bcc_result_t out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg_r.click_window   <= CLICK_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_CLICK_WINDOW:   cfg_r.click_window   <= cfg_wdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign step      = in_valid_r && load_ready;
  assign in_tready = !in_valid_r || load_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_level_r <= in_tdata[0];
    end
  end

  bcc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (in_level_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  bcc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_data  (res),
    .load_ready (load_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_data)
  );

  assign out_tdata = {{(OUT_DATA_W - $bits(bcc_result_t)){1'b0}}, out_data};

endmodule

`default_nettype wire

// ----- tb/button_click_classifier_unit_tb.sv -----
`timescale 1ns / 1ps

module button_click_classifier_unit_tb;
  import bcc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned SHOW_MAX    = 10;

  typedef enum {PLAN_TOGGLE, PLAN_CLICKS, PLAN_HOLD} plan_kind_t;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  raw;
    bit                    typed;
    bcc_result_t           want;
  } tick_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Own copy of the classifier state and its registers.
  bcc_cfg_t            model_cfg;
  logic [LIMIT_W-1:0]  integ;
  logic                held;
  logic [WINDOW_W-1:0] win_left;
  logic [TALLY_W-1:0]  tally;
  logic [MODE_W-1:0]   mode;
  logic [LAMP_N-1:0]   lamps;

  bcc_result_t  expected_ticks[$];
  tick_row_t    directed_rows[$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  src_pct = 0;
  int unsigned  sink_pct = 0;
  bit           hold_sink_req = 0;

  button_click_classifier_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [0] raw_level, rest zero
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] pressed_level, [1] single_click, [2] double_click,
                              // [6:3] lamps green..blue, [14:7] mode_now, [15] zero
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_model();
    model_cfg.debounce_limit = DEBOUNCE_LIMIT_RST;
    model_cfg.click_window   = CLICK_WINDOW_RST;
    integ    = '0;
    held     = 1'b0;
    win_left = '0;
    tally    = '0;
    mode     = '0;
    lamps    = '0;
  endtask

  // One sampling tick: the window counts down first, then the level is debounced,
  // then a closed window with presses pending is classified.
  task automatic classify_tick(input logic raw, output bcc_result_t res);
    res = '0;
    if (win_left != 0) win_left = win_left - 1'b1;
    if (raw) begin
      if (integ < model_cfg.debounce_limit) begin
        integ = integ + 1'b1;
      end else if (!held) begin
        if (win_left == 0) win_left = model_cfg.click_window;
        if (tally != TALLY_MAX) tally = tally + 1'b1;
        held = 1'b1;
      end
    end else begin
      if (integ != 0) integ = integ - 1'b1;
      else held = 1'b0;
    end
    if (win_left == 0 && tally != 0) begin
      if (tally > 1) begin
        res.double_click = 1'b1;
        mode  = '0;
        lamps = '0;
      end else begin
        res.single_click = 1'b1;
        if (mode < LAMP_N) lamps[mode[1:0]] = 1'b1;
        mode = mode + 1'b1;
      end
      tally = '0;
    end
    res.pressed_level = held;
    res.lamps         = lamps;
    res.mode_now      = mode;
  endtask

  function automatic bcc_result_t result_of(logic pl, logic sc, logic dc,
                                            logic [LAMP_N-1:0] lit, logic [MODE_W-1:0] m);
    bcc_result_t r;
    r.pressed_level = pl;
    r.single_click  = sc;
    r.double_click  = dc;
    r.lamps         = lit;
    r.mode_now      = m;
    return r;
  endfunction

  function automatic void add_tick(logic raw, bit typed = 1'b0, bcc_result_t want = '0);
    tick_row_t row;
    row = '{is_write: 1'b0, idx: '0, val: '0, raw: raw, typed: typed, want: want};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    tick_row_t row;
    row = '{is_write: 1'b1, idx: idx, val: val, raw: 1'b0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_tick(input logic raw, input bit typed, input bcc_result_t want);
    bcc_result_t res;
    int unsigned n;
    if (src_pct != 0 && $urandom_range(1, 100) <= src_pct) begin
      n = idle_len();
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, raw};
    do @(posedge clk); while (in_tready !== 1'b1);
    classify_tick(raw, res);
    expected_ticks.push_back(typed ? want : res);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE_LIMIT: model_cfg.debounce_limit = val[LIMIT_W-1:0];
      REG_CLICK_WINDOW:   model_cfg.click_window   = val[WINDOW_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input logic [WINDOW_W-1:0] win,
                           input int unsigned count, input plan_kind_t kind,
                           input int unsigned src, input int unsigned snk,
                           input bit squeeze, input bit mid_drain);
    logic        plan[$];
    int unsigned presses;
    int unsigned reps;
    int unsigned k;
    drain_results();
    // The upper byte of a limit write carries junk that the block must drop.
    write_reg(REG_DEBOUNCE_LIMIT, {8'($urandom_range(0, 255)), lim});
    write_reg(REG_CLICK_WINDOW, win);
    src_pct  = src;
    sink_pct = snk;
    hold_sink_req = squeeze;
    while (plan.size() < count) begin
      case (kind)
        PLAN_TOGGLE: plan.push_back(plan.size() % 2 == 0);
        PLAN_HOLD:   plan.push_back($urandom_range(0, 9) != 0);
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            // Contact bounce with no structure at all.
            reps = $urandom_range(1, 8);
            repeat (reps) plan.push_back($urandom_range(0, 1));
          end else begin
            presses = $urandom_range(1, 5);
            repeat (presses) begin
              reps = lim + 1 + $urandom_range(0, 3);
              repeat (reps) plan.push_back(1'b1);
              if ($urandom_range(0, 3) == 0) begin
                plan.push_back(1'b0);
                plan.push_back(1'b1);
              end
              reps = lim + 1 + $urandom_range(0, 3);
              repeat (reps) plan.push_back(1'b0);
            end
            reps = (win < count) ? win + $urandom_range(1, 6) : count;
            repeat (reps) plan.push_back(1'b0);
          end
        end
      endcase
    end
    for (k = 0; k < count; k++) begin
      if (mid_drain && k == count / 2) drain_results();
      send_tick(plan[k], 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : sink
    int unsigned n;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_sink_req) begin
        hold_sink_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_pct != 0 && $urandom_range(1, 100) <= sink_pct) begin
        n = idle_len();
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic note_fault(input string what, input bcc_result_t want, input bcc_result_t got);
    if (error_count < SHOW_MAX)
      $display("ERROR %s at %0t: expected pressed %0b single %0b double %0b lamps %b mode %0d,",
               what, $realtime, want.pressed_level, want.single_click, want.double_click,
               want.lamps, want.mode_now);
    if (error_count < SHOW_MAX)
      $display("      got pressed %0b single %0b double %0b lamps %b mode %0d",
               got.pressed_level, got.single_click, got.double_click, got.lamps, got.mode_now);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    bcc_result_t got;
    bcc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = bcc_result_t'(out_tdata[$bits(bcc_result_t)-1:0]);
      if (expected_ticks.size() == 0) begin
        note_fault("unexpected word", '0, got);
      end else begin
        want = expected_ticks.pop_front();
        if (got.pressed_level !== want.pressed_level || got.single_click !== want.single_click ||
            got.double_click !== want.double_click || got.lamps[0] !== want.lamps[0] ||
            got.lamps[1] !== want.lamps[1] || got.lamps[2] !== want.lamps[2] ||
            got.lamps[3] !== want.lamps[3] || got.mode_now !== want.mode_now)
          note_fault("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    tick_row_t row;
    int unsigned i;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    reset_model();

    // Straight after reset the default limit holds the integrator well below a press.
    add_tick(1'b0, 1'b1, result_of(1'b0, 1'b0, 1'b0, 4'b0000, 8'd0));
    add_tick(1'b1, 1'b1, result_of(1'b0, 1'b0, 1'b0, 4'b0000, 8'd0));
    add_tick(1'b0, 1'b1, result_of(1'b0, 1'b0, 1'b0, 4'b0000, 8'd0));
    // No debouncing and no window: every press is a single click on the spot,
    // walking the lamps and then on past the last one.
    add_write(REG_DEBOUNCE_LIMIT, 16'd0);
    add_write(REG_CLICK_WINDOW, 16'd0);
    add_tick(1'b1, 1'b1, result_of(1'b1, 1'b1, 1'b0, 4'b0001, 8'd1));
    add_tick(1'b1, 1'b1, result_of(1'b1, 1'b0, 1'b0, 4'b0001, 8'd1));
    add_tick(1'b0, 1'b1, result_of(1'b0, 1'b0, 1'b0, 4'b0001, 8'd1));
    add_tick(1'b1, 1'b1, result_of(1'b1, 1'b1, 1'b0, 4'b0011, 8'd2));
    add_tick(1'b0);
    add_tick(1'b1, 1'b1, result_of(1'b1, 1'b1, 1'b0, 4'b0111, 8'd3));
    add_tick(1'b0);
    add_tick(1'b1, 1'b1, result_of(1'b1, 1'b1, 1'b0, 4'b1111, 8'd4));
    add_tick(1'b0, 1'b1, result_of(1'b0, 1'b0, 1'b0, 4'b1111, 8'd4));
    add_tick(1'b1);
    add_tick(1'b0);
    // Four presses inside one window: the tally saturates, then all lamps go out.
    add_write(REG_CLICK_WINDOW, 16'd8);
    for (i = 0; i < 8; i++) add_tick(i % 2 == 0);
    add_tick(1'b0, 1'b1, result_of(1'b0, 1'b0, 1'b1, 4'b0000, 8'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_pct  = 20;
    sink_pct = 20;
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.is_write) begin
        drain_results();
        write_reg(row.idx, row.val);
      end else begin
        send_tick(row.raw, row.typed, row.want);
      end
    end

    // Long run of clean clicks so that the mode index wraps past its top.
    run_phase(8'd0,   16'd0,     520, PLAN_TOGGLE, 0,  0,  1'b0, 1'b0);
    run_phase(8'd1,   16'd16,    200, PLAN_CLICKS, 15, 25, 1'b1, 1'b0);
    run_phase(8'd0,   16'd6,     120, PLAN_CLICKS, 30, 10, 1'b0, 1'b0);
    // Build the integrator up under the top limit, then lower the limit beneath it.
    run_phase(8'd255, 16'd1,     60,  PLAN_HOLD,   10, 10, 1'b0, 1'b0);
    run_phase(8'd4,   16'd30,    150, PLAN_CLICKS, 25, 30, 1'b0, 1'b1);
    run_phase(8'd3,   16'd20,    120, PLAN_CLICKS, 0,  40, 1'b0, 1'b0);
    run_phase(8'd7,   16'hFFFF,  60,  PLAN_CLICKS, 20, 20, 1'b0, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    error_count += expected_ticks.size();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- button_click_classifier_unit.f -----
src/bcc_pkg.sv
src/bcc_core.sv
src/bcc_out_reg.sv
src/button_click_classifier_unit.sv
tb/button_click_classifier_unit_tb.sv
